### rtl/piecewise_cubic_bezier_joint_sampler_defines.svh
// assertion macros for the bezier joint sampler
`ifndef PIECEWISE_CUBIC_BEZIER_JOINT_SAMPLER_DEFINES_SVH
`define PIECEWISE_CUBIC_BEZIER_JOINT_SAMPLER_DEFINES_SVH

// implication checked at every edge outside reset
`define PCB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pcbjs_pkg.sv
// ----------------------------------------------------------------------------
// pcbjs_pkg
// types, constants and helpers shared by the bezier joint sampler
// ----------------------------------------------------------------------------
package pcbjs_pkg;

  localparam int MaxJoints   = 32;
  localparam int MaxSegments = 16;
  localparam int JW = $clog2(MaxJoints);
  localparam int SW = $clog2(MaxSegments);
  localparam int TFRAC = 28;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_LOADSEG = 2'd1;
  localparam logic [1:0] OP_LOADLIM = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  localparam logic [1:0] CFG_TICK_PERIOD = 2'd0;
  localparam logic [1:0] CFG_TOTAL_TIME  = 2'd1;
  localparam logic [1:0] CFG_JOINT_COUNT = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [4:0]         joint;
    logic [3:0]         segment;
    logic [31:0]        seg_start;
    logic [31:0]        seg_end;
    logic signed [31:0] point_start;
    logic signed [31:0] point_out;
    logic signed [31:0] point_in;
    logic signed [31:0] point_end;
    logic signed [31:0] limit_low;
    logic signed [31:0] limit_high;
    logic               limit_enabled;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         joint_index;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic [25:0]        progress_ms;
    logic               finished;
    logic               last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       load_seg;
    logic       load_lim;
    logic       restart;
    logic       tick_begin;   // advance time
    logic       joint_begin;  // restart segment search
    logic       seg_read;     // issue segment read
    logic       seg_check;    // compare read entry
    logic       div_start;
    logic       div_step;
    logic [3:0] eval_step;    // eval sequence index
    logic       emit;
    logic [JW-1:0] joint;
    logic       last;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic found;       // current entry ends at or after elapsed
    logic seg_last;    // searched entry is last of count
    logic no_segs;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sd2147483647) return 32'sh7fffffff;
    if (v < -38'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

### rtl/pcbjs_ctrl.sv
// ----------------------------------------------------------------------------
// pcbjs_ctrl
// sequencer: applies loads and restart, walks joints, segment search, divide and evaluation steps
// ----------------------------------------------------------------------------
`include "piecewise_cubic_bezier_joint_sampler_defines.svh"
module pcbjs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_start,
  input  logic [1:0]           op,
  input  logic [5:0]           joint_count,
  input  logic                 plan_ready,
  input  pcbjs_pkg::sts_t      sts,
  output logic                 in_busy,
  output pcbjs_pkg::ctl_t      ctl
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_EVAL = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_JNT  = 3'd6;

  localparam int CntW = pcbjs_pkg::JW + 1;
  localparam int EvalSteps = 8;

  logic [2:0] state_r, state_nxt;
  logic [CntW-1:0] n_r, n_nxt;
  logic [pcbjs_pkg::JW-1:0] j_r, j_nxt;
  logic [4:0] dcnt_r, dcnt_nxt;
  logic [3:0] ecnt_r, ecnt_nxt;
  logic accept;
  logic [CntW-1:0] ncap;

  assign accept = in_start && !in_busy;
  assign in_busy = (state_r != S_IDLE);
  assign ncap = (joint_count > 6'(pcbjs_pkg::MaxJoints)) ?
                CntW'(pcbjs_pkg::MaxJoints) : CntW'(joint_count);

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r;
    j_nxt = j_r;
    dcnt_nxt = dcnt_r;
    ecnt_nxt = ecnt_r;
    ctl = '0;
    ctl.joint = j_r;
    ctl.last = ({1'b0, j_r} + 1'b1) == n_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            pcbjs_pkg::OP_LOADSEG: ctl.load_seg = 1'b1;
            pcbjs_pkg::OP_LOADLIM: ctl.load_lim = 1'b1;
            pcbjs_pkg::OP_RESTART: ctl.restart = 1'b1;
            default: begin
              if (plan_ready && joint_count != '0) begin
                ctl.tick_begin = 1'b1;
                n_nxt = ncap;
                j_nxt = '0;
                state_nxt = S_JNT;
              end
            end
          endcase
        end
      end
      S_JNT: begin
        ctl.joint_begin = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        ctl.seg_read = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.no_segs) begin
          state_nxt = S_EMIT;
        end else begin
          ctl.seg_check = 1'b1;
          if (sts.found || sts.seg_last) begin
            ctl.div_start = 1'b1;
            dcnt_nxt = '0;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == 5'(pcbjs_pkg::TFRAC - 1)) begin
          ecnt_nxt = '0;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        ctl.eval_step = ecnt_r;
        ecnt_nxt = ecnt_r + 1'b1;
        if (ecnt_r == 4'(EvalSteps - 1)) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        ctl.emit = 1'b1;
        if (ctl.last) begin
          state_nxt = S_IDLE;
        end else begin
          j_nxt = j_r + 1'b1;
          state_nxt = S_JNT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      n_r <= '0;
      j_r <= '0;
      dcnt_r <= '0;
      ecnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      n_r <= n_nxt;
      j_r <= j_nxt;
      dcnt_r <= dcnt_nxt;
      ecnt_r <= ecnt_nxt;
    end
  end

  `PCB_ASSERT_IMP(a_emit_in_emit, clk, rst_n, ctl.emit, state_r == S_EMIT, "emit outside emit")
  `PCB_ASSERT_NXT(a_tick_busy, clk, rst_n, ctl.tick_begin, in_busy, "tick did not go busy")
  `PCB_ASSERT_IMP(a_joint_range, clk, rst_n, in_busy, {1'b0, j_r} < n_r, "joint beyond count")
endmodule

### rtl/pcbjs_dp.sv
// ----------------------------------------------------------------------------
// pcbjs_dp
// tables, time keeping, serial divider and de casteljau evaluation
// ----------------------------------------------------------------------------
`include "piecewise_cubic_bezier_joint_sampler_defines.svh"
module pcbjs_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pcbjs_pkg::in_item_t   item,
  input  pcbjs_pkg::ctl_t       ctl,
  input  logic [15:0]           tick_period,
  input  logic [31:0]           total_time,
  output logic                  plan_ready,
  output pcbjs_pkg::sts_t       sts,
  output logic                  out_strobe,
  output pcbjs_pkg::out_item_t  out_item
);
  localparam int JW = pcbjs_pkg::JW;
  localparam int SW = pcbjs_pkg::SW;
  localparam int AW = JW + SW;
  localparam int Depth = pcbjs_pkg::MaxJoints * pcbjs_pkg::MaxSegments;
  localparam logic [28:0] TOne = 29'd1 << pcbjs_pkg::TFRAC;

  // segment memory
  logic [191:0] seg_mem [Depth];
  logic [191:0] rd_r;
  logic [SW:0]  cnt_r [pcbjs_pkg::MaxJoints];
  logic signed [31:0] llo_r [pcbjs_pkg::MaxJoints];
  logic signed [31:0] lhi_r [pcbjs_pkg::MaxJoints];
  logic [pcbjs_pkg::MaxJoints-1:0] lon_r;
  logic plan_r;
  logic [31:0] el_r;
  logic [SW-1:0] q_r;
  logic [SW:0] jcnt;
  logic [31:0] t0, t1;
  logic signed [31:0] p0, p1, p2, p3;

  assign jcnt = cnt_r[ctl.joint];
  assign {t0, t1, p0, p1, p2, p3} = rd_r;
  assign plan_ready = plan_r;
  assign sts.found = el_r <= t1;
  assign sts.seg_last = ({1'b0, q_r} + 1'b1) == jcnt;
  assign sts.no_segs = (jcnt == '0);

  always_ff @(posedge clk) begin
    if (ctl.load_seg) seg_mem[{item.joint[JW-1:0], item.segment[SW-1:0]}] <=
        {item.seg_start, item.seg_end, item.point_start, item.point_out,
         item.point_in, item.point_end};
    if (ctl.seg_read) rd_r <= seg_mem[AW'({ctl.joint, q_r})];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pcbjs_pkg::MaxJoints; i++) cnt_r[i] <= '0;
      lon_r <= '0;
      plan_r <= 1'b0;
      el_r <= '0;
    end else begin
      if (ctl.load_seg) cnt_r[item.joint[JW-1:0]] <= {1'b0, item.segment[SW-1:0]} + 1'b1;
      if (ctl.load_lim) lon_r[item.joint[JW-1:0]] <= item.limit_enabled;
      if (ctl.restart) begin
        for (int i = 0; i < pcbjs_pkg::MaxJoints; i++) cnt_r[i] <= '0;
        el_r <= '0;
        plan_r <= 1'b1;
      end
      if (ctl.tick_begin) begin
        el_r <= ({1'b0, el_r} + {17'd0, tick_period} > 33'hffffffff) ? 32'hffffffff :
                el_r + {16'd0, tick_period};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pcbjs_pkg::MaxJoints; i++) begin
        llo_r[i] <= '0;
        lhi_r[i] <= '0;
      end
    end else if (ctl.load_lim) begin
      llo_r[item.joint[JW-1:0]] <= item.limit_low;
      lhi_r[item.joint[JW-1:0]] <= item.limit_high;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.joint_begin) q_r <= '0;
    else if (ctl.seg_check && !sts.found && !sts.seg_last) q_r <= q_r + 1'b1;
  end

  // time shared per tick
  logic [31:0] tc;
  logic [25:0] ms_r;
  logic fin_r;
  logic [41:0] ms_full;
  assign tc = (el_r < total_time) ? el_r : total_time;
  assign ms_full = {10'd0, el_r} * 42'd1000;
  always_ff @(posedge clk) begin
    ms_r <= ms_full[41:16];
    fin_r <= el_r >= total_time;
  end

  // restoring divider, one quotient bit a step
  logic signed [32:0] num, den;
  logic [32:0] rem_r, den_r, qt_r;
  logic [28:0] t_r;
  logic tsp_r;
  logic [33:0] trial;
  assign num = $signed({1'b0, tc}) - $signed({1'b0, t0});
  assign den = $signed({1'b0, t1}) - $signed({1'b0, t0});
  assign trial = {rem_r, 1'b0} - {1'b0, den_r};
  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      tsp_r <= 1'b0;
      qt_r <= '0;
      den_r <= den[32] ? 33'(-den) : 33'(den);
      rem_r <= num[32] ? 33'(-num) : 33'(num);
      if (den == 0) begin
        tsp_r <= 1'b1; t_r <= (num > 0) ? TOne : '0;
      end else if (num == 0 || (num[32] != den[32])) begin
        tsp_r <= 1'b1; t_r <= '0;
      end else if ((num[32] ? -num : num) >= (den[32] ? -den : den)) begin
        tsp_r <= 1'b1; t_r <= TOne;
      end
    end else if (ctl.div_step) begin
      if (!trial[33]) begin
        rem_r <= trial[32:0];
        qt_r <= {qt_r[31:0], 1'b1};
      end else begin
        rem_r <= {rem_r[31:0], 1'b0};
        qt_r <= {qt_r[31:0], 1'b0};
      end
    end
  end

  // evaluation, one lerp per step
  logic signed [31:0] a0_r, a1_r, a2_r, b0_r, b1_r, pos_r;
  logic [28:0] t;
  logic signed [31:0] la, lb;
  logic signed [62:0] prod;
  logic signed [62:0] prod_r;
  logic signed [31:0] la_r;
  logic signed [33:0] lres;
  assign t = tsp_r ? t_r : {1'b0, qt_r[27:0]};
  always_comb begin
    case (ctl.eval_step)
      4'd0: begin la = p0; lb = p1; end
      4'd1: begin la = p1; lb = p2; end
      4'd2: begin la = p2; lb = p3; end
      4'd3: begin la = a0_r; lb = a1_r; end
      4'd4: begin la = a1_r; lb = a2_r; end
      default: begin la = b0_r; lb = b1_r; end
    endcase
  end
  // multiply registered, add on next step
  assign prod = (($signed({lb[31], lb}) - $signed({la[31], la})) *
                 $signed({1'b0, t})) ;
  assign lres = $signed({{2{la_r[31]}}, la_r}) + 34'(prod_r >>> pcbjs_pkg::TFRAC);
  logic [3:0] ev_idx_r;
  always_ff @(posedge clk) begin
    prod_r <= prod;
    la_r <= la;
    ev_idx_r <= ctl.eval_step;
    case (ev_idx_r)
      4'd0: a0_r <= lres[31:0];
      4'd1: a1_r <= lres[31:0];
      4'd2: a2_r <= lres[31:0];
      4'd3: b0_r <= lres[31:0];
      4'd4: b1_r <= lres[31:0];
      4'd6: pos_r <= lres[31:0];   // step six, once b1 has landed
      default: ;
    endcase
  end

  // derivatives and clamp
  logic signed [37:0] vel_w, acc_w;
  logic signed [31:0] posc;
  assign vel_w = 38'sd3 * ($signed({{6{b1_r[31]}}, b1_r}) - $signed({{6{b0_r[31]}}, b0_r}));
  assign acc_w = 38'sd6 * ($signed({{6{a2_r[31]}}, a2_r}) - 38'sd2 *
                 $signed({{6{a1_r[31]}}, a1_r}) + $signed({{6{a0_r[31]}}, a0_r}));
  always_comb begin
    posc = pos_r;
    if (lon_r[ctl.joint]) begin
      if (pos_r < llo_r[ctl.joint]) posc = llo_r[ctl.joint];
      else if (lhi_r[ctl.joint] < pos_r) posc = lhi_r[ctl.joint];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else out_strobe <= ctl.emit;
    if (ctl.emit) begin
      out_item.joint_index <= 5'(ctl.joint);
      out_item.progress_ms <= ms_r;
      out_item.finished <= fin_r;
      out_item.last <= ctl.last;
      if (sts.no_segs) begin
        out_item.position <= '0;
        out_item.velocity <= '0;
        out_item.acceleration <= '0;
      end else begin
        out_item.position <= posc;
        out_item.velocity <= pcbjs_pkg::sat32(vel_w);
        out_item.acceleration <= pcbjs_pkg::sat32(acc_w);
      end
    end
  end

  `PCB_ASSERT_NXT(a_strobe, clk, rst_n, ctl.emit, out_strobe, "emit lost")
  `PCB_ASSERT_NXT(a_restart_clears, clk, rst_n, ctl.restart, el_r == '0 && plan_r, "restart")
  `PCB_ASSERT_IMP(a_tick_ready, clk, rst_n, ctl.tick_begin, plan_r, "tick before restart")
endmodule

### rtl/piecewise_cubic_bezier_joint_sampler.sv
// a tick holds busy while each joint runs segment search, divide and evaluation and emits;
// a joint without segments skips divide and evaluation, and each extra searched segment
// adds a read and check; the 28-step serial divider and 8 lerp steps set the per-joint time
// loads and restart apply without going busy; each joint result strobes out for one cycle
// synchronous active-low reset clears counts, limits, time and sequencer state and sets
// configuration defaults; the receiver cannot stall; segment memory is not cleared by reset
// ----------------------------------------------------------------------------
// piecewise_cubic_bezier_joint_sampler
// per-joint cubic bezier segment table sampled on each tick
// ----------------------------------------------------------------------------
module piecewise_cubic_bezier_joint_sampler (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_start,
  output logic                  in_busy,
  input  pcbjs_pkg::in_item_t   in_item,
  output logic                  out_strobe,
  output pcbjs_pkg::out_item_t  out_item,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  // configuration registers
  logic [15:0] tick_period_r;
  logic [31:0] total_time_r;
  logic [5:0]  joint_count_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_period_r <= 16'd655;
      total_time_r <= '0;
      joint_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pcbjs_pkg::CFG_TICK_PERIOD: tick_period_r <= cfg_data[15:0];
        pcbjs_pkg::CFG_TOTAL_TIME:  total_time_r <= cfg_data;
        pcbjs_pkg::CFG_JOINT_COUNT: joint_count_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  pcbjs_pkg::ctl_t ctl;
  pcbjs_pkg::sts_t sts;
  logic plan_ready;

  // command sequencer
  pcbjs_ctrl u_ctrl (
    .clk, .rst_n, .in_start,
    .op(in_item.operation),
    .joint_count(joint_count_r),
    .plan_ready,
    .sts, .in_busy, .ctl
  );

  // storage and arithmetic
  pcbjs_dp u_dp (
    .clk, .rst_n,
    .item(in_item),
    .ctl,
    .tick_period(tick_period_r),
    .total_time(total_time_r),
    .plan_ready,
    .sts,
    .out_strobe,
    .out_item
  );
endmodule

### dv/tb_piecewise_cubic_bezier_joint_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_cubic_bezier_joint_sampler
// drives segment loads, limit loads, restarts and ticks into the joint
// sampler and checks every joint result against a cycle-free predictor
// ----------------------------------------------------------------------------
module tb_piecewise_cubic_bezier_joint_sampler;

  localparam int  PHASES    = 5;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int  MAXJ  = pcbjs_pkg::MaxJoints;
  localparam int  MAXS  = pcbjs_pkg::MaxSegments;
  localparam int  TFRAC = pcbjs_pkg::TFRAC;

  logic      clk;
  logic      rst_n;
  logic      in_start;
  logic      in_busy;
  pcbjs_pkg::in_item_t  in_item;
  logic      out_strobe;
  pcbjs_pkg::out_item_t out_item;
  logic      cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  piecewise_cubic_bezier_joint_sampler dut (
    .clk(clk), .rst_n(rst_n),
    .in_start(in_start), .in_busy(in_busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of configuration and state
  logic [15:0] pr_period;
  logic [31:0] pr_total;
  logic [5:0]  pr_joints;
  logic [31:0] pr_elapsed;
  bit          pr_ready;
  logic [31:0] seg_t0 [MAXJ][MAXS];
  logic [31:0] seg_t1 [MAXJ][MAXS];
  logic signed [31:0] seg_pt [MAXJ][MAXS][4];
  bit          seg_written [MAXJ][MAXS];
  int          seg_count [MAXJ];
  logic signed [31:0] lim_lo [MAXJ];
  logic signed [31:0] lim_hi [MAXJ];
  bit          lim_on [MAXJ];

  pcbjs_pkg::out_item_t pending_joints[$];   // joint results still owed by the block
  int        errors;
  int        results_seen;
  int        ticks_sent;
  longint    cycles;

  // directed rows: item plus an optional hand-written first result
  typedef struct {
    pcbjs_pkg::in_item_t item;
    bit       typed;
    pcbjs_pkg::out_item_t first;
  } dir_row_t;
  dir_row_t dir_rows[$];

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run-away guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL piecewise_cubic_bezier_joint_sampler");
      $finish;
    end
  end

  // ---------------- predictor ----------------

  function automatic longint lerp28(longint a, longint b, longint t);
    longint p;
    p = (b - a) * t;
    return a + (p >>> TFRAC);   // arithmetic shift floors toward minus infinity
  endfunction

  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // normalized segment parameter in U1.28
  function automatic longint norm_t(longint num, longint den);
    longint an;
    longint ad;
    if (den == 0) return (num > 0) ? (64'sd1 <<< TFRAC) : 0;
    if (num == 0 || ((num < 0) != (den < 0))) return 0;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    if (an >= ad) return 64'sd1 <<< TFRAC;
    return (an <<< TFRAC) / ad;
  endfunction

  function automatic void cfg_model(logic [1:0] idx, logic [31:0] val);
    case (idx)
      pcbjs_pkg::CFG_TICK_PERIOD: pr_period = val[15:0];
      pcbjs_pkg::CFG_TOTAL_TIME:  pr_total  = val;
      pcbjs_pkg::CFG_JOINT_COUNT: pr_joints = val[5:0];
      default: ;
    endcase
  endfunction

  // applies one accepted item and queues the joint results it causes
  function automatic void sample_joints(pcbjs_pkg::in_item_t it);
    int n;
    int k;
    longint e;
    longint tc;
    longint num;
    longint den;
    longint t;
    longint a0, a1, a2, b0, b1, pos, vel, acc;
    logic [63:0] ms;
    pcbjs_pkg::out_item_t r;
    case (it.operation)
      pcbjs_pkg::OP_LOADSEG: begin
        seg_t0[it.joint][it.segment] = it.seg_start;
        seg_t1[it.joint][it.segment] = it.seg_end;
        seg_pt[it.joint][it.segment][0] = it.point_start;
        seg_pt[it.joint][it.segment][1] = it.point_out;
        seg_pt[it.joint][it.segment][2] = it.point_in;
        seg_pt[it.joint][it.segment][3] = it.point_end;
        seg_written[it.joint][it.segment] = 1'b1;
        seg_count[it.joint] = int'(it.segment) + 1;
      end
      pcbjs_pkg::OP_LOADLIM: begin
        lim_lo[it.joint] = it.limit_low;
        lim_hi[it.joint] = it.limit_high;
        lim_on[it.joint] = it.limit_enabled;
      end
      pcbjs_pkg::OP_RESTART: begin
        foreach (seg_count[j]) seg_count[j] = 0;
        pr_elapsed = '0;
        pr_ready = 1'b1;
      end
      default: begin
        if (!pr_ready || pr_joints == 0) return;
        n = (int'(pr_joints) > MAXJ) ? MAXJ : int'(pr_joints);
        e = longint'(pr_elapsed) + longint'(pr_period);
        pr_elapsed = (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
        tc = longint'((pr_elapsed < pr_total) ? pr_elapsed : pr_total);
        ms = (64'(pr_elapsed) * 64'd1000) >> 16;
        for (int i = 0; i < n; i++) begin
          pos = 0; vel = 0; acc = 0;
          if (seg_count[i] > 0) begin
            // first segment ending at or after now, else the last one
            k = seg_count[i] - 1;
            for (int q = 0; q < seg_count[i]; q++) begin
              if (pr_elapsed <= seg_t1[i][q]) begin
                k = q;
                break;
              end
            end
            num = tc - longint'(seg_t0[i][k]);
            den = longint'(seg_t1[i][k]) - longint'(seg_t0[i][k]);
            t = norm_t(num, den);
            a0 = lerp28(longint'(seg_pt[i][k][0]), longint'(seg_pt[i][k][1]), t);
            a1 = lerp28(longint'(seg_pt[i][k][1]), longint'(seg_pt[i][k][2]), t);
            a2 = lerp28(longint'(seg_pt[i][k][2]), longint'(seg_pt[i][k][3]), t);
            b0 = lerp28(a0, a1, t);
            b1 = lerp28(a1, a2, t);
            pos = lerp28(b0, b1, t);
            vel = sat_q(3 * (b1 - b0));
            acc = sat_q(6 * (a2 - 2 * a1 + a0));
            if (lim_on[i]) begin
              if (pos < longint'(lim_lo[i])) pos = longint'(lim_lo[i]);
              else if (longint'(lim_hi[i]) < pos) pos = longint'(lim_hi[i]);
            end
          end
          r.joint_index  = i[4:0];
          r.position     = pos[31:0];
          r.velocity     = vel[31:0];
          r.acceleration = acc[31:0];
          r.progress_ms  = ms[25:0];
          r.finished     = (pr_elapsed >= pr_total);
          r.last         = (i + 1 == n);
          pending_joints = {pending_joints, r};
        end
      end
    endcase
  endfunction

  // ---------------- result checking ----------------

  always @(posedge clk) begin
    pcbjs_pkg::out_item_t w;
    if (rst_n && out_strobe) begin
      results_seen++;
      if (pending_joints.size() == 0) begin
        $error("joint result with nothing expected: joint_index %0d", out_item.joint_index);
        errors++;
      end else begin
        w = pending_joints.pop_front();
        if (out_item.joint_index !== w.joint_index) begin
          $error("joint_index exp %0d got %0d", w.joint_index, out_item.joint_index);
          errors++;
        end
        if (out_item.position !== w.position) begin
          $error("position exp %h got %h", w.position, out_item.position);
          errors++;
        end
        if (out_item.velocity !== w.velocity) begin
          $error("velocity exp %h got %h", w.velocity, out_item.velocity);
          errors++;
        end
        if (out_item.acceleration !== w.acceleration) begin
          $error("acceleration exp %h got %h", w.acceleration, out_item.acceleration);
          errors++;
        end
        if (out_item.progress_ms !== w.progress_ms) begin
          $error("progress_ms exp %0d got %0d", w.progress_ms, out_item.progress_ms);
          errors++;
        end
        if (out_item.finished !== w.finished) begin
          $error("finished exp %0b got %0b", w.finished, out_item.finished);
          errors++;
        end
        if (out_item.last !== w.last) begin
          $error("last exp %0b got %0b", w.last, out_item.last);
          errors++;
        end
      end
    end
  end

  // ---------------- stimulus helpers ----------------

  function automatic pcbjs_pkg::in_item_t seg_item(int j, int s,
                                                   logic [31:0] t0, logic [31:0] t1,
                                                   logic [31:0] p0, logic [31:0] p1,
                                                   logic [31:0] p2, logic [31:0] p3);
    pcbjs_pkg::in_item_t it;
    it = '0;
    it.operation = pcbjs_pkg::OP_LOADSEG;
    it.joint = j[4:0];
    it.segment = s[3:0];
    it.seg_start = t0;
    it.seg_end = t1;
    it.point_start = p0;
    it.point_out = p1;
    it.point_in = p2;
    it.point_end = p3;
    return it;
  endfunction

  function automatic pcbjs_pkg::in_item_t lim_item(int j, logic [31:0] lo, logic [31:0] hi,
                                                   bit en);
    pcbjs_pkg::in_item_t it;
    it = '0;
    it.operation = pcbjs_pkg::OP_LOADLIM;
    it.joint = j[4:0];
    it.limit_low = lo;
    it.limit_high = hi;
    it.limit_enabled = en;
    return it;
  endfunction

  function automatic pcbjs_pkg::in_item_t op_item(logic [1:0] op);
    pcbjs_pkg::in_item_t it;
    it = '0;
    it.operation = op;
    return it;
  endfunction

  function automatic void add_row(pcbjs_pkg::in_item_t it);
    dir_row_t r;
    r.item = it;
    r.typed = 1'b0;
    r.first = '0;
    dir_rows = {dir_rows, r};
  endfunction

  // number of segments from index 0 up that have all been written
  function automatic int written_prefix(int j);
    int p;
    p = 0;
    while (p < MAXS && seg_written[j][p]) p++;
    return p;
  endfunction

  function automatic logic [31:0] rand_point();
    logic [31:0] v;
    v = $urandom();
    if ($urandom_range(0, 3) != 0) v = {{6{v[25]}}, v[25:0]};   // mostly a 26-bit signed value
    return v;
  endfunction

  // a tick, segment load, limit load or restart; segments mostly well-formed near now, sometimes noise
  function automatic pcbjs_pkg::in_item_t rand_item();
    pcbjs_pkg::in_item_t it;
    int j;
    int pre;
    int pick;
    logic [31:0] t0;
    it = '0;
    it.joint = 5'($urandom());
    it.limit_enabled = ($urandom_range(0, 1) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      it.operation = pcbjs_pkg::OP_TICK;
      it.seg_start = $urandom();   // don't-care fields still wiggle
    end else if (pick < 80) begin
      j = ($urandom_range(0, 3) != 0 && pr_joints > 0) ?
          $urandom_range(0, (int'(pr_joints) > MAXJ ? MAXJ : int'(pr_joints)) - 1) :
          $urandom_range(0, MAXJ - 1);
      pre = written_prefix(j);
      if (pre >= MAXS) pre = MAXS - 1;
      t0 = ($urandom_range(0, 5) == 0) ? $urandom() :
           pr_elapsed + $urandom_range(0, 32'h0004_0000) - 32'h0001_0000;
      it = seg_item(j, ($urandom_range(0, 1) != 0) ? pre : $urandom_range(0, pre), t0,
                    ($urandom_range(0, 5) == 0) ? $urandom() :
                    t0 + $urandom_range(0, 32'h0004_0000),
                    rand_point(), rand_point(), rand_point(), rand_point());
    end else if (pick < 95) begin
      it = lim_item($urandom_range(0, MAXJ - 1), rand_point(), rand_point(),
                    $urandom_range(0, 1) != 0);
    end else begin
      it.operation = pcbjs_pkg::OP_RESTART;
    end
    return it;
  endfunction

  // ---------------- driving ----------------

  int sender_idle_pct;

  // present one item; start stays high afterwards unless the sender idles
  task automatic send_item(pcbjs_pkg::in_item_t it);
    @(negedge clk);
    in_item  <= it;
    in_start <= 1'b1;
    forever begin
      @(posedge clk);
      if (!in_busy) break;
    end
    sample_joints(it);
    if (it.operation == pcbjs_pkg::OP_TICK) ticks_sent++;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      in_start <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  endtask

  // drop start before the block frees up, drain all owed results, then wait a bit
  task automatic settle();
    @(negedge clk);
    in_start <= 1'b0;
    while (pending_joints.size() != 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_cfg(logic [15:0] period, logic [31:0] total, logic [5:0] joints);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= pcbjs_pkg::CFG_TICK_PERIOD; cfg_data <= {16'd0, period};
    cfg_model(pcbjs_pkg::CFG_TICK_PERIOD, {16'd0, period});
    @(negedge clk);
    cfg_index <= pcbjs_pkg::CFG_TOTAL_TIME; cfg_data <= total;
    cfg_model(pcbjs_pkg::CFG_TOTAL_TIME, total);
    @(negedge clk);
    cfg_index <= pcbjs_pkg::CFG_JOINT_COUNT; cfg_data <= {26'd0, joints};
    cfg_model(pcbjs_pkg::CFG_JOINT_COUNT, {26'd0, joints});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------- main sequence ----------------

  initial begin
    // per-phase settings: period, total time, joints, sender idle, items
    logic [15:0] ph_period [PHASES];
    logic [31:0] ph_total  [PHASES];
    logic [5:0]  ph_joints [PHASES];
    int          ph_idle   [PHASES];
    int          ph_items  [PHASES];
    dir_row_t    row;
    pcbjs_pkg::out_item_t got;

    ph_period = '{16'd65535, 16'd1, 16'd0, 16'd40000, 16'd655};
    ph_total  = '{32'h0010_0000, 32'hFFFF_FFFF, 32'd0, 32'h0080_0000, 32'h0002_0000};
    ph_joints = '{6'd32, 6'd7, 6'd0, 6'd17, 6'd1};
    ph_idle   = '{11, 78, 78, 0, 0};
    ph_items  = '{110, 100, 15, 110, 20};

    cycles = 0; errors = 0; results_seen = 0; ticks_sent = 0;
    in_start = 1'b0; in_item = '0;
    cfg_we = 1'b0; cfg_index = pcbjs_pkg::CFG_TICK_PERIOD; cfg_data = '0;
    rst_n = 1'b0;
    pr_period = 16'd655; pr_total = '0; pr_joints = '0; pr_elapsed = '0; pr_ready = 1'b0;
    foreach (seg_count[j]) begin
      seg_count[j] = 0; lim_lo[j] = '0; lim_hi[j] = '0; lim_on[j] = 1'b0;
      for (int s = 0; s < MAXS; s++) seg_written[j][s] = 1'b0;
    end
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed part: three joints, five-second plan
    write_cfg(16'd655, 32'h0005_0000, 6'd3);
    add_row(op_item(pcbjs_pkg::OP_TICK));      // plan not ready: no results
    add_row(op_item(pcbjs_pkg::OP_RESTART));
    row.item = op_item(pcbjs_pkg::OP_TICK);    // no segments anywhere: zeros
    row.typed = 1'b1;
    row.first = '{joint_index: 5'd0, position: '0, velocity: '0, acceleration: '0,
                  progress_ms: 26'd9, finished: 1'b0, last: 1'b0};
    dir_rows = {dir_rows, row};
    // full-scale control points, then an empty span, then an inverted span
    add_row(seg_item(0, 0, 32'd0, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF));
    add_row(seg_item(0, 1, 32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h8000_0000));
    add_row(seg_item(1, 0, 32'h0002_0000, 32'd0, 32'h0100_0000, 32'h0200_0000,
                     32'hFF00_0000, 32'h0000_0001));
    add_row(seg_item(2, 0, 32'd0, 32'hFFFF_FFFF, 32'h0400_0000, 32'hFC00_0000,
                     32'h0400_0000, 32'hFC00_0000));
    add_row(lim_item(2, 32'h0100_0000, 32'hFF00_0000, 1'b1));  // inverted limits
    add_row(lim_item(0, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0));
    add_row(op_item(pcbjs_pkg::OP_TICK));
    add_row(lim_item(0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
    add_row(op_item(pcbjs_pkg::OP_TICK));
    add_row(lim_item(0, 32'hFFFF_0000, 32'h0001_0000, 1'b1));  // clamps both ways
    add_row(op_item(pcbjs_pkg::OP_TICK));
    add_row(seg_item(31, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF));
    add_row(op_item(pcbjs_pkg::OP_TICK));
    add_row(op_item(pcbjs_pkg::OP_RESTART));   // counts cleared, entries kept
    add_row(op_item(pcbjs_pkg::OP_TICK));
    add_row(seg_item(0, 0, 32'd0, 32'h0000_0800, 32'd0, 32'h0000_1000,
                     32'h0000_2000, 32'h0000_3000));
    add_row(op_item(pcbjs_pkg::OP_TICK));
    add_row(op_item(pcbjs_pkg::OP_TICK));

    sender_idle_pct = 11;
    foreach (dir_rows[r]) begin
      send_item(dir_rows[r].item);
      if (dir_rows[r].typed) begin
        if (pending_joints.size() == 0) begin
          $error("directed row %0d: no result predicted", r);
          errors++;
        end else begin
          got = pending_joints[0];
          if (got !== dir_rows[r].first) begin
            $error("directed row %0d: hand-written result disagrees with prediction", r);
            errors++;
          end
        end
      end
    end
    settle();

    // random part over several settings and sender idle rates
    for (int p = 0; p < PHASES; p++) begin
      write_cfg(ph_period[p], ph_total[p], ph_joints[p]);
      sender_idle_pct = ph_idle[p];
      if (p == 0) send_item(op_item(pcbjs_pkg::OP_RESTART));
      for (int i = 0; i < ph_items[p]; i++) send_item(rand_item());
      settle();
    end

    // wait out anything left in flight
    while (pending_joints.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d ticks and %0d joint results over %0d register settings",
             ticks_sent, results_seen, PHASES + 1);
    if (errors == 0) begin
      $display("PASS piecewise_cubic_bezier_joint_sampler");
    end else begin
      $display("FAIL piecewise_cubic_bezier_joint_sampler");
    end
    $finish;
  end

endmodule
